// ===== src/egfu_pkg.sv =====
// Shared types and constants for the encoder glitch filter and unwrap block.
// No dependencies; imported by every module of the block.
`default_nettype none

package egfu_pkg;

    localparam int RAW_W  = 16;
    localparam int POS_W  = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;
    localparam int TRUST_W = 3;
    localparam int PER_W  = 17;
    localparam int PP_W   = 7;
    localparam int PP_N   = 128;

    localparam int DIV_BITS  = 4;   // quotient bits resolved per cycle
    localparam int DIV_STEPS = RAW_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [15:0] THIRD_TURN     = 16'd21845;
    localparam logic [15:0] TWO_THIRD_TURN = 16'd43690;
    localparam logic [16:0] ONE_TURN       = 17'h10000;
    localparam logic [16:0] HALF_TURN      = 17'h08000;

    // floor(x / 5) for x below 2^18 as (x * FIFTH_RECIP) >> FIFTH_SHIFT
    localparam logic [17:0] FIFTH_RECIP = 18'd209716;
    localparam int          FIFTH_SHIFT = 20;

    // Register map
    localparam logic [IDX_W-1:0] REG_ENCODER_BIAS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_POSITION_BIAS = 3'd1;
    localparam logic [IDX_W-1:0] REG_LAG_GAIN      = 3'd2;
    localparam logic [IDX_W-1:0] REG_POLE_PAIRS    = 3'd3;
    localparam logic [IDX_W-1:0] REG_JUMP_LIMIT    = 3'd4;

    localparam logic [15:0]       ENCODER_BIAS_RST  = 16'd0;
    localparam logic [POS_W-1:0]  POSITION_BIAS_RST = 32'd0;
    localparam logic [15:0]       LAG_GAIN_RST      = 16'd24904;
    localparam logic [14:0]       JUMP_LIMIT_RST    = 15'd500;
    localparam logic [PER_W-1:0]  PERIOD_RST        = 17'h10000;
    localparam logic signed [TRUST_W-1:0] TRUST_RST = -3'sd2;
    localparam logic signed [TRUST_W-1:0] TRUST_MAX = 3'sd2;

    typedef logic [PP_N-1:0][PER_W-1:0] period_table_t;

    // round(65536 / pp) by long division, pole pair count of zero acts as one
    function automatic logic [PER_W-1:0] period_of(input int pp_in);
        logic [PER_W-1:0] num;
        logic [PER_W:0]   rem;
        logic [PER_W-1:0] quo;
        int               pp;
        pp  = (pp_in == 0) ? 1 : pp_in;
        num = 17'h10000 + PER_W'(pp >> 1);
        rem = '0;
        quo = '0;
        for (int i = PER_W - 1; i >= 0; i--) begin
            rem = {rem[PER_W-1:0], num[i]};
            if (rem >= (PER_W+1)'(pp)) begin
                rem    = rem - (PER_W+1)'(pp);
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic period_table_t build_period_table();
        period_table_t t;
        for (int i = 0; i < PP_N; i++) begin
            t[i] = period_of(i);
        end
        return t;
    endfunction

    localparam period_table_t PERIOD_TABLE = build_period_table();

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRED,
        S_ERR,
        S_MUL,
        S_LAG,
        S_DIV,
        S_DONE
    } egfu_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic pred;
        logic err;
        logic mul;
        logic lag;
        logic div;
        logic div_first;
        logic load_out;
    } egfu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } egfu_status_t;

endpackage

`default_nettype wire

// ===== src/encoder_glitch_filter_unwrap.sv =====
// Top level of the encoder glitch filter and multiturn unwrap.
// Depends on egfu_pkg, egfu_ctrl (sequencer) and egfu_dp (datapath).
//
// Usage notes
//  - s_ channel: one raw 16-bit encoder reading per beat, taken when
//    s_tvalid and s_tready are both high. s_tready is high only while the
//    sequencer is idle; one sample is in flight at a time.
//  - m_ channel: one result beat per sample, held in an output register
//    until m_tready; a waiting result does not block the next sample from
//    being taken, only the hand-over of the following result.
//  - A new sample is taken only once the last one has passed PRED, MUL,
//    ERR, LAG, DIV and DONE; the electrical sub-angle remainder in DIV is
//    worked four bits a cycle.
//  - cfg channel: register index and data; always ready, write only while
//    idle. The pole pair count is turned into its electrical period on
//    the write itself.
//  - Reset (aresetn low, synchronous): registers to their defaults, trust
//    counter back to untrusted, history and multiturn count to zero,
//    output beat dropped.
//  - If the receiver stalls, the sequencer holds its finished sample and
//    takes no new beat until the output register frees up.
`default_nettype none

module encoder_glitch_filter_unwrap
    import egfu_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // raw_angle [15:0]
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [RAW_W-1:0]   s_tdata,
    // filtered_angle [15:0], angle_delta [31:16],
    // multiturn_position [63:32], elec_sub_angle [79:64]
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [79:0]             m_tdata,
    // replaced [0]
    output logic [0:0]              m_tuser,
    // configuration writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data
);

    egfu_cmd_t    cmd;
    egfu_status_t status;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    egfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    egfu_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .raw_angle (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== src/egfu_ctrl.sv =====
// Sequencer for the encoder filter: steps one sample through the datapath.
// Depends on egfu_pkg (state enum, command and status structs).
`default_nettype none

module egfu_ctrl
    import egfu_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire egfu_status_t status,
    output egfu_cmd_t         cmd
);

    egfu_state_t            state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // seam lift and |step| first, then the 4/5 multiply, then the decision, the lag term and the remainder
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_PRED;
            end
            S_PRED: state_next = S_MUL;
            S_MUL:  state_next = S_ERR;
            S_ERR:  state_next = S_LAG;
            S_LAG: begin
                state_next = S_DIV;
                cnt_next   = '0;
            end
            S_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) state_next = S_DONE;
            end
            S_DONE: begin
                if (status.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_PRED: cmd.pred = 1'b1;
            S_ERR:  cmd.err  = 1'b1;
            S_MUL:  cmd.mul  = 1'b1;
            S_LAG:  cmd.lag  = 1'b1;
            S_DIV: begin
                cmd.div       = 1'b1;
                cmd.div_first = (cnt_reg == '0);
            end
            S_DONE: cmd.load_out = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/egfu_dp.sv =====
// Datapath: bias removal, glitch prediction, lag term, unwrap, electrical modulo.
// Depends on egfu_pkg; sequenced by egfu_ctrl through egfu_cmd_t.
`default_nettype none

module egfu_dp
    import egfu_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [RAW_W-1:0]   raw_angle,
    input  wire logic               cfg_valid,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire egfu_cmd_t          cmd,
    output egfu_status_t            status,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [79:0]             m_tdata,
    output logic [0:0]              m_tuser
);

    // configuration
    logic [15:0]       enc_bias_reg;
    logic [POS_W-1:0]  pos_bias_reg;
    logic [15:0]       lag_gain_reg;
    logic [14:0]       jump_reg;
    logic [PER_W-1:0]  period_reg;

    // filter state
    logic [15:0]                 prev_reg, hist_old_reg, hist_new_reg;
    logic signed [TRUST_W-1:0]   trust_reg, trust_next;
    logic [POS_W-1:0]            unwrap_reg, unwrap_next;

    // per-sample working registers
    logic [15:0]        noc_reg;
    logic signed [15:0] meas_reg;
    logic               bypass_reg;
    logic [17:0]        n_abs_reg;
    logic               d_neg_reg;
    logic signed [15:0] step_reg;
    logic [16:0]        h1l_reg, srl_reg;
    logic [15:0]        angle_pre_reg, angle_pre_next;
    logic signed [15:0] delta_reg, delta_next;
    logic               repl_reg, repl_next;
    logic signed [32:0] prod_reg;
    logic [15:0]        angle_f_reg;
    logic [16:0]        rem_reg, rem_next;
    logic [15:0]        dvd_reg, dvd_next;
    logic [POS_W-1:0]   pos_reg;

    logic               m_tvalid_reg;
    logic [79:0]        m_tdata_reg;
    logic               m_tuser_reg;

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // input stage
    logic [15:0] noc;
    assign noc = raw_angle - enc_bias_reg;

    // prediction stage
    logic        lo0, lo1, lift, sr_up;
    logic [16:0] h0l, h1l, srl, hd;
    logic signed [15:0] d;
    logic [15:0] d_abs;
    logic [17:0] n_abs;
    logic signed [16:0] hdiff;
    logic [16:0] hdiff_abs;
    logic        bypass;

    always_comb begin
        lo0   = hist_old_reg < THIRD_TURN;
        lo1   = hist_new_reg < THIRD_TURN;
        lift  = (lo0 || hist_old_reg >= TWO_THIRD_TURN) && (lo1 || hist_new_reg >= TWO_THIRD_TURN);
        sr_up = lift && ((lo0 && lo1) ? (noc_reg < TWO_THIRD_TURN) : (noc_reg < THIRD_TURN));
        h0l   = {1'b0, hist_old_reg} + ((lift && lo0) ? ONE_TURN : 17'd0);
        h1l   = {1'b0, hist_new_reg} + ((lift && lo1) ? ONE_TURN : 17'd0);
        srl   = {1'b0, noc_reg} + (sr_up ? ONE_TURN : 17'd0);
        hd    = h1l - h0l;
        d     = $signed(hd[15:0]);
        d_abs = d[15] ? (16'd0 - d) : d;            // -32768 gives 32768
        n_abs = {d_abs, 2'b00} + 18'd2;             // 4|d| + 2
        hdiff = $signed({1'b0, hist_new_reg}) - $signed({1'b0, hist_old_reg});
        hdiff_abs = hdiff[16] ? 17'(-hdiff) : 17'(hdiff);
        bypass = trust_reg[TRUST_W-1] || (hdiff_abs > {2'b00, jump_reg});
    end

    // step stage: round(4|d| / 5) by reciprocal multiplication
    logic [35:0] q_full;
    logic [15:0] q;
    always_comb begin
        q_full = n_abs_reg * FIFTH_RECIP;
        q      = q_full[FIFTH_SHIFT+15:FIFTH_SHIFT];
    end

    // decision stage
    logic signed [18:0] est, err;
    logic [18:0]        err_abs;
    logic               reject;

    always_comb begin
        est     = $signed({2'b00, h1l_reg}) + 19'(step_reg);
        err     = $signed({2'b00, srl_reg}) - est;
        err_abs = err[18] ? 19'(-err) : 19'(err);
        reject  = err_abs > {4'b0000, jump_reg};

        angle_pre_next = noc_reg;
        delta_next     = meas_reg;
        repl_next      = 1'b0;
        trust_next     = trust_reg;
        if (bypass_reg) begin
            if (trust_reg[TRUST_W-1]) trust_next = trust_reg + 3'sd1;
        end else if (reject) begin
            angle_pre_next = est[15:0];
            delta_next     = step_reg;
            repl_next      = 1'b1;
            trust_next     = (trust_reg == TRUST_MAX) ? TRUST_RST : trust_reg + 3'sd1;
        end else begin
            trust_next = '0;
        end
    end

    // lag term: truncate toward zero, keep low 16 bits
    logic signed [33:0] total;
    logic [15:0]        angle_f;
    always_comb begin
        total   = $signed({2'b00, angle_pre_reg, 16'h0000}) + 34'(prod_reg);
        angle_f = total[31:16] + {15'd0, total[33] && (total[15:0] != 16'h0000)};
    end

    // unwrap to a multiturn count
    logic [16:0] gap;
    logic [15:0] turns;
    always_comb begin
        gap   = ({1'b0, unwrap_reg[15:0]} >= {1'b0, angle_f_reg})
              ? ({1'b0, unwrap_reg[15:0]} - {1'b0, angle_f_reg})
              : ({1'b0, angle_f_reg} - {1'b0, unwrap_reg[15:0]});
        turns = unwrap_reg[31:16];
        if (gap > HALF_TURN) begin
            turns = angle_f_reg[15] ? (turns - 16'd1) : (turns + 16'd1);
        end
        unwrap_next = {turns, angle_f_reg};
    end

    // restoring remainder, DIV_BITS bits per cycle
    logic [17:0] trial;
    always_comb begin
        rem_next = cmd.div_first ? 17'd0 : rem_reg;
        dvd_next = cmd.div_first ? angle_f_reg : dvd_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial    = {rem_next, dvd_next[15]};
            dvd_next = {dvd_next[14:0], 1'b0};
            if (trial >= {1'b0, period_reg}) trial = trial - {1'b0, period_reg};
            rem_next = trial[16:0];
        end
    end

    // control-side state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_bias_reg <= ENCODER_BIAS_RST;
            pos_bias_reg <= POSITION_BIAS_RST;
            lag_gain_reg <= LAG_GAIN_RST;
            jump_reg     <= JUMP_LIMIT_RST;
            period_reg   <= PERIOD_RST;
            prev_reg     <= '0;
            hist_old_reg <= '0;
            hist_new_reg <= '0;
            trust_reg    <= TRUST_RST;
            unwrap_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_ENCODER_BIAS:  enc_bias_reg <= cfg_data[15:0];
                    REG_POSITION_BIAS: pos_bias_reg <= cfg_data;
                    REG_LAG_GAIN:      lag_gain_reg <= cfg_data[15:0];
                    REG_POLE_PAIRS:    period_reg   <= PERIOD_TABLE[cfg_data[PP_W-1:0]];
                    REG_JUMP_LIMIT:    jump_reg     <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (cmd.load_in) prev_reg <= noc;
            if (cmd.err) begin
                trust_reg    <= trust_next;
                hist_old_reg <= hist_new_reg;
                hist_new_reg <= angle_pre_next;
            end
            if (cmd.div_first) unwrap_reg <= unwrap_next;
            if (cmd.load_out) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            noc_reg  <= noc;
            meas_reg <= $signed(noc - prev_reg);
        end
        if (cmd.pred) begin
            bypass_reg <= bypass;
            n_abs_reg  <= n_abs;
            d_neg_reg  <= d[15];
            h1l_reg    <= h1l;
            srl_reg    <= srl;
            prod_reg   <= meas_reg * $signed({1'b0, lag_gain_reg});
        end
        if (cmd.mul) step_reg <= d_neg_reg ? $signed(16'd0 - q) : $signed(q);
        if (cmd.err) begin
            angle_pre_reg <= angle_pre_next;
            delta_reg     <= delta_next;
            repl_reg      <= repl_next;
        end
        if (cmd.lag) angle_f_reg <= angle_f;
        if (cmd.div) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
        if (cmd.div_first) pos_reg <= unwrap_next - pos_bias_reg;
        if (cmd.load_out) begin
            m_tdata_reg <= {rem_reg[15:0], pos_reg, delta_reg, angle_f_reg};
            m_tuser_reg <= repl_reg;
        end
    end

endmodule

`default_nettype wire

// ===== sim/egfu_checker.sv =====
// Scoreboard for the encoder glitch filter and unwrap: watches the s_, m_ and cfg channels,
// predicts every result beat from the accepted readings and compares field by field.
// Depends on egfu_pkg for the register map, widths and reset values.
module egfu_checker
    import egfu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [RAW_W-1:0]   s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [79:0]        m_tdata,
    input  logic [0:0]         m_tuser,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output int                 mismatches,
    output int                 awaiting,
    output int                 substitutions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TURN = 65536;

    typedef struct packed {
        logic [15:0]        angle;
        logic signed [15:0] delta;
        logic [POS_W-1:0]   position;
        logic [15:0]        sub_angle;
        logic               replaced;
    } angle_sample_t;

    angle_sample_t pending_samples[$];

    // register copies
    logic [15:0]      enc_bias_r;
    logic [POS_W-1:0] pos_bias_r;
    logic [15:0]      gain_r;
    logic [PP_W-1:0]  pp_r;
    logic [14:0]      jlim_r;

    // filter state
    logic [15:0]      last_noc;
    logic [15:0]      hist_old;
    logic [15:0]      hist_new;
    int               trust;
    logic [POS_W-1:0] turns_pos;
    int               beats_seen;

    initial begin
        mismatches    = 0;
        awaiting      = 0;
        substitutions = 0;
        beats_seen    = 0;
    end

    task automatic flag_mismatch(input string msg);
        $display("egfu_checker: beat %0d: %s", beats_seen, msg);
        mismatches++;
    endtask

    // 4/5 of a signed step, rounded half away from zero
    function automatic int four_fifths_step(input int d);
        int n;
        n = 4 * d;
        if (n >= 0)
            return (n + 2) / 5;
        return -((-n + 2) / 5);
    endfunction

    function automatic angle_sample_t predict_sample(input logic [15:0] raw);
        logic [15:0]   noc;
        logic [15:0]   ang;
        logic [15:0]   diff16;
        int            meas, dlt, hd, jl, h0, h1, sr, stp, est, err, low, gap, a_i, pp, period;
        bit            lo0, lo1, out0, out1;
        logic          rep;
        longint        a_l, g_l, total, whole;
        angle_sample_t r;

        noc    = raw - enc_bias_r;
        diff16 = noc - last_noc;
        meas   = $signed(diff16);
        last_noc = noc;

        h0 = hist_old;
        h1 = hist_new;
        jl = jlim_r;
        hd = h1 - h0;
        if (hd < 0)
            hd = -hd;
        rep = 1'b0;

        if (trust < 0 || hd > jl) begin
            // untrusted or jumpy history: pass the reading through
            ang = noc;
            dlt = meas;
            if (trust < 0)
                trust++;
        end else begin
            sr   = noc;
            lo0  = hist_old < THIRD_TURN;
            lo1  = hist_new < THIRD_TURN;
            out0 = lo0 || hist_old >= TWO_THIRD_TURN;
            out1 = lo1 || hist_new >= TWO_THIRD_TURN;
            // history near the seam: lift the low side above one turn
            if (out0 && out1) begin
                if (lo0 && lo1) begin
                    if (noc < TWO_THIRD_TURN)
                        sr += TURN;
                end else begin
                    if (noc < THIRD_TURN)
                        sr += TURN;
                end
                if (lo0)
                    h0 += TURN;
                if (lo1)
                    h1 += TURN;
            end
            diff16 = 16'(h1 - h0);
            stp = four_fifths_step($signed(diff16));
            est = h1 + stp;
            err = sr - est;
            if (err < 0)
                err = -err;
            if (err > jl) begin
                ang = 16'(est);
                dlt = stp;
                rep = 1'b1;
                trust++;
                if (trust > 2)
                    trust = -2;
            end else begin
                ang   = noc;
                dlt   = meas;
                trust = 0;
            end
        end

        hist_old = hist_new;
        hist_new = ang;

        // lag term always from the measured delta, truncated toward zero
        a_l   = ang;
        g_l   = gain_r;
        total = a_l * 65536 + longint'(meas) * g_l;
        whole = total / 65536;
        ang   = 16'(whole);

        low = turns_pos[15:0];
        a_i = ang;
        gap = low - a_i;
        if (gap < 0)
            gap = -gap;
        if (gap > 32768) begin
            if (ang < 16'h8000)
                turns_pos += 32'h10000;
            else
                turns_pos -= 32'h10000;
        end
        turns_pos = {turns_pos[31:16], ang};

        pp = pp_r;
        if (pp == 0)
            pp = 1;
        period = (TURN + pp / 2) / pp;

        r.angle     = ang;
        r.delta     = 16'(dlt);
        r.position  = turns_pos - pos_bias_r;
        r.sub_angle = 16'(a_i % period);
        r.replaced  = rep;
        return r;
    endfunction

    always @(posedge aclk) begin
        angle_sample_t want;
        angle_sample_t got;
        if (!aresetn) begin
            enc_bias_r = ENCODER_BIAS_RST;
            pos_bias_r = POSITION_BIAS_RST;
            gain_r     = LAG_GAIN_RST;
            pp_r       = 7'd1;
            jlim_r     = JUMP_LIMIT_RST;
            last_noc   = '0;
            hist_old   = '0;
            hist_new   = '0;
            trust      = -2;
            turns_pos  = '0;
            pending_samples.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ENCODER_BIAS:  enc_bias_r = cfg_data[15:0];
                    REG_POSITION_BIAS: pos_bias_r = cfg_data;
                    REG_LAG_GAIN:      gain_r     = cfg_data[15:0];
                    REG_POLE_PAIRS:    pp_r       = cfg_data[PP_W-1:0];
                    REG_JUMP_LIMIT:    jlim_r     = cfg_data[14:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = predict_sample(s_tdata);
                if (want.replaced)
                    substitutions++;
                pending_samples.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.angle     = m_tdata[15:0];
                got.delta     = m_tdata[31:16];
                got.position  = m_tdata[63:32];
                got.sub_angle = m_tdata[79:64];
                got.replaced  = m_tuser[0];
                if (pending_samples.size() == 0) begin
                    flag_mismatch($sformatf("result beat with nothing expected (tdata %h)",
                                            m_tdata));
                end else begin
                    want = pending_samples.pop_front();
                    if (got.angle !== want.angle)
                        flag_mismatch($sformatf("filtered_angle %h, want %h",
                                                got.angle, want.angle));
                    if (got.delta !== want.delta)
                        flag_mismatch($sformatf("angle_delta %h, want %h",
                                                got.delta, want.delta));
                    if (got.position !== want.position)
                        flag_mismatch($sformatf("multiturn_position %h, want %h",
                                                got.position, want.position));
                    if (got.sub_angle !== want.sub_angle)
                        flag_mismatch($sformatf("elec_sub_angle %h, want %h",
                                                got.sub_angle, want.sub_angle));
                    if (got.replaced !== want.replaced)
                        flag_mismatch($sformatf("replaced %b, want %b",
                                                got.replaced, want.replaced));
                end
                beats_seen++;
            end
        end
        awaiting = pending_samples.size();
    end

endmodule

// ===== sim/encoder_glitch_filter_unwrap_tb.sv =====
// Testbench top for encoder_glitch_filter_unwrap: clock, reset, register writes,
// encoder readings, receiver back-pressure and the verdict. Needs egfu_pkg and egfu_checker.
module encoder_glitch_filter_unwrap_tb
    import egfu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES     = 9;
    localparam int PHASE_ITEMS    = 200;
    localparam int HOLD_PHASE     = 3;
    localparam int LONG_HOLD      = 240;   // receiver hold-off, cycles
    localparam int DRAIN_CYCLES   = 12;    // margin after the last expected result
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on any channel

    // indexes the block must ignore
    localparam logic [IDX_W-1:0] REG_SPARE_FIRST = REG_JUMP_LIMIT + 1'b1;
    localparam logic [IDX_W-1:0] REG_SPARE_LAST  = '1;

    // directed readings, default registers: range extremes, largest deltas,
    // forward seam crossing, a single glitch, three glitches forcing a resync,
    // then a backward seam crossing
    localparam logic [15:0] DIRECTED [23] = '{
        16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
        16'd65400, 16'd65450, 16'd65500, 16'd14, 16'd64, 16'd114,
        16'd30000, 16'd214,
        16'd40000, 16'd50000, 16'd60000,
        16'd500, 16'd550, 16'd600,
        16'd120, 16'd60, 16'd0, 16'd65476, 16'd65416
    };

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic [RAW_W-1:0]   s_tdata   = '0;
    logic               m_tready  = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;
    wire                s_tready;
    wire                m_tvalid;
    wire  [79:0]        m_tdata;
    wire  [0:0]         m_tuser;
    wire                cfg_ready;

    int mismatches;
    int awaiting;
    int substitutions;

    // stimulus-side knowledge of the current setting, for shaping readings
    logic [15:0] cur_enc_bias = ENCODER_BIAS_RST;
    int          cur_jlim     = JUMP_LIMIT_RST;
    int          shaft        = 0;
    int          items_sent   = 0;
    bit          idle_on      = 1'b1;
    bit          hold_req     = 1'b0;
    int          quiet        = 0;

    always #5 aclk = ~aclk;

    encoder_glitch_filter_unwrap i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    egfu_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .awaiting      (awaiting),
        .substitutions (substitutions)
    );

    // watchdog: any beat on any channel restarts the count
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", quiet);
                $display("[encoder_glitch_filter_unwrap] ERROR");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one reading; returns on the falling edge after its beat.
    // tvalid stays high so a following call carries straight on.
    task automatic offer(input logic [15:0] raw);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // stop offering, let every expected result arrive and the block go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (awaiting != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // junk above the register width; the block must drop it
    function automatic logic [CFG_W-1:0] pad_upper(input logic [CFG_W-1:0] value,
                                                   input int width);
        logic [CFG_W-1:0] mask;
        mask = (CFG_W'(1) << width) - 1;
        return ($urandom() & ~mask) | (value & mask);
    endfunction

    // Rotating shaft: segments of steady speed with noise scaled to the
    // jump limit, single glitches, and runs of glitches long enough to resync.
    task automatic run_shaft(input int count);
        int          n, seg_left, vel, spread, b, jl, glitch_left, noise, pick;
        logic [15:0] raw;
        seg_left    = 0;
        glitch_left = 0;
        vel         = 0;
        spread      = 1;
        jl          = cur_jlim;
        for (n = 0; n < count; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 40);
                case ($urandom_range(0, 3))
                    0:       b = 20;
                    1:       b = jl + 1;
                    2:       b = (5 * jl + 5 > 32767) ? 32767 : 5 * jl + 5;
                    default: b = 32767;
                endcase
                vel    = int'($urandom_range(0, 2 * b)) - b;
                spread = ($urandom_range(0, 3) == 0) ? 2 * jl + 2 : jl / 4 + 1;
                if (spread > 32767)
                    spread = 32767;
            end
            seg_left--;
            shaft = (shaft + vel) & 16'hFFFF;
            noise = int'($urandom_range(0, 2 * spread)) - spread;
            if (glitch_left == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    glitch_left = 1;
                else if (pick < 6)
                    glitch_left = 2;
                else if (pick < 9)
                    glitch_left = $urandom_range(3, 4);
            end
            if (glitch_left > 0) begin
                raw = 16'($urandom());
                glitch_left--;
            end else begin
                raw = 16'(shaft + noise) + cur_enc_bias;
            end
            offer(raw);
        end
    endtask

    initial begin
        int               ph;
        logic [15:0]      enc, gain;
        logic [POS_W-1:0] pos;
        logic [PP_W-1:0]  pp;
        logic [14:0]      jl;

        // synchronous reset, released on a falling edge
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values in force: directed readings first
        foreach (DIRECTED[i])
            offer(DIRECTED[i]);
        settle();

        // an unmapped index must change nothing
        write_reg(REG_SPARE_FIRST, $urandom());
        offer(16'h1234);
        offer(16'h1240);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin   // encoder bias, lag gain and jump limit at their top, zero pole pairs
                    enc = 16'hFFFF; pos = 32'h8000_0000; gain = 16'hFFFF;
                    pp = 7'd0; jl = 15'h7FFF;
                end
                1: begin   // encoder bias, lag gain and jump limit at their bottom, 64 pole pairs
                    enc = 16'h0000; pos = 32'h7FFF_FFFF; gain = 16'h0000;
                    pp = 7'd64; jl = 15'd0;
                end
                2: begin
                    enc = 16'($urandom()); pos = $urandom(); gain = 16'($urandom());
                    pp = 7'h7F; jl = JUMP_LIMIT_RST;
                end
                default: begin
                    enc  = 16'($urandom());
                    pos  = $urandom();
                    gain = 16'($urandom());
                    pp   = 7'($urandom_range(1, 64));
                    jl   = ($urandom_range(0, 1) != 0) ? 15'($urandom_range(0, 2000))
                                                       : 15'($urandom());
                end
            endcase
            cur_enc_bias = enc;
            cur_jlim     = jl;
            write_reg(REG_ENCODER_BIAS,  pad_upper(enc, 16));
            write_reg(REG_POSITION_BIAS, pos);
            write_reg(REG_LAG_GAIN,      pad_upper(gain, 16));
            write_reg(REG_POLE_PAIRS,    pad_upper(pp, PP_W));
            write_reg(REG_JUMP_LIMIT,    pad_upper(jl, 15));
            if ($urandom_range(0, 1) != 0)
                write_reg(IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());

            // last phase runs flat out on both sides
            idle_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (ph == HOLD_PHASE)
                hold_req = 1'b1;    // receiver stops while readings keep coming
            run_shaft(PHASE_ITEMS);
        end

        s_tvalid <= 1'b0;
        do @(negedge aclk); while (awaiting != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("run covered %0d encoder readings over %0d register settings, %0d substituted",
                 items_sent, NUM_PHASES + 1, substitutions);
        $display("random stalls on both sides and one %0d-cycle receiver hold-off", LONG_HOLD);
        if (mismatches == 0 && awaiting == 0)
            $display("[encoder_glitch_filter_unwrap] OK");
        else
            $display("[encoder_glitch_filter_unwrap] ERROR");
        $finish;
    end

endmodule
